// ===== hdl/tcpc_pkg.sv =====
// shared constants, types and control store for the text console
`default_nettype none
package tcpc_pkg;

    localparam int COLUMNS      = 32;
    localparam int SCREEN_CELLS = 512;
    localparam int ROWS         = SCREEN_CELLS / COLUMNS;
    localparam int ADDR_W       = $clog2(SCREEN_CELLS);
    localparam int COL_W        = $clog2(COLUMNS);
    localparam int ROW_W        = ADDR_W - COL_W;
    localparam int BOTTOM_ROW   = SCREEN_CELLS - COLUMNS;
    localparam int CHAR_W       = 8;
    localparam int S_TDATA_W    = ((CHAR_W + ADDR_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((CHAR_W + ADDR_W + 1 + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] NEWLINE     = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK       = 8'h20;
    localparam logic [CHAR_W-1:0] CURSOR_MARK = 8'hFF;
    localparam logic [CHAR_W-1:0] FILL        = 8'h2F;
    localparam logic [CHAR_W-1:0] CTRL_GLYPH  = 8'h1F;

    typedef logic [3:0] step_t;

    localparam step_t STEP_INIT     = 4'd0;
    localparam step_t STEP_IDLE     = 4'd1;
    localparam step_t STEP_DISPATCH = 4'd2;
    localparam step_t STEP_KIND     = 4'd3;
    localparam step_t STEP_CHAR     = 4'd4;
    localparam step_t STEP_MARK     = 4'd5;
    localparam step_t STEP_NL_FILL  = 4'd6;
    localparam step_t STEP_SCROLL   = 4'd7;
    localparam step_t STEP_CLEAR    = 4'd8;
    localparam step_t STEP_MARK_ROW = 4'd9;
    localparam step_t STEP_READ     = 4'd10;
    localparam step_t STEP_DONE     = 4'd11;

    typedef enum logic [1:0] {D_CHAR, D_BLANK, D_MARK, D_INIT} dsel_t;
    typedef enum logic [1:0] {A_CURSOR, A_PTR, A_READ, A_INIT} asel_t;
    typedef enum logic [1:0] {P_HOLD, P_LOAD, P_INC, P_CLEAR} ptr_op_t;
    typedef enum logic [1:0] {C_HOLD, C_INC, C_ZERO} cur_op_t;
    typedef enum logic [2:0] {
        COND_ALWAYS, COND_IN_ACCEPT, COND_MODE_READ, COND_NEWLINE,
        COND_COL_LAST, COND_PTR_MORE, COND_INIT_MORE, COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic    in_ready;
        logic    we;
        dsel_t   dsel;
        asel_t   asel;
        logic    re;
        ptr_op_t ptr_op;
        cur_op_t cur_op;
        logic    top_inc;
        logic    scr_clr;
        logic    scr_set;
        logic    init_inc;
        logic    out_load;
        logic    stay;
        cond_t   cond;
        step_t   target;
    } ctrl_t;

    // control store: jump to target when cond holds, else stay or fall through
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t c;
        c = '0;
        case (step)
            STEP_INIT:
            begin
                c.we = 1'b1; c.dsel = D_INIT; c.asel = A_INIT; c.init_inc = 1'b1;
                c.cond = COND_INIT_MORE; c.target = STEP_INIT;
            end
            STEP_IDLE:
            begin
                c.in_ready = 1'b1; c.stay = 1'b1;
                c.cond = COND_IN_ACCEPT; c.target = STEP_DISPATCH;
            end
            STEP_DISPATCH:
            begin
                c.ptr_op = P_LOAD; c.scr_clr = 1'b1;
                c.cond = COND_MODE_READ; c.target = STEP_READ;
            end
            STEP_KIND:
            begin
                c.cond = COND_NEWLINE; c.target = STEP_NL_FILL;
            end
            STEP_CHAR:
            begin
                c.we = 1'b1; c.dsel = D_CHAR; c.asel = A_CURSOR; c.cur_op = C_INC;
                c.cond = COND_COL_LAST; c.target = STEP_SCROLL;
            end
            STEP_MARK, STEP_MARK_ROW:
            begin
                c.we = 1'b1; c.dsel = D_MARK; c.asel = A_CURSOR;
                c.cond = COND_ALWAYS; c.target = STEP_DONE;
            end
            STEP_NL_FILL:
            begin
                c.we = 1'b1; c.dsel = D_BLANK; c.asel = A_PTR; c.ptr_op = P_INC;
                c.cond = COND_PTR_MORE; c.target = STEP_NL_FILL;
            end
            STEP_SCROLL:
            begin
                c.top_inc = 1'b1; c.ptr_op = P_CLEAR; c.cur_op = C_ZERO; c.scr_set = 1'b1;
                c.cond = COND_ALWAYS; c.target = STEP_CLEAR;
            end
            STEP_CLEAR:
            begin
                c.we = 1'b1; c.dsel = D_BLANK; c.asel = A_PTR; c.ptr_op = P_INC;
                c.cond = COND_PTR_MORE; c.target = STEP_CLEAR;
            end
            STEP_READ:
            begin
                c.re = 1'b1; c.asel = A_READ;
                c.cond = COND_ALWAYS; c.target = STEP_DONE;
            end
            STEP_DONE:
            begin
                c.out_load = 1'b1; c.stay = 1'b1;
                c.cond = COND_OUT_FREE; c.target = STEP_IDLE;
            end
            default:
            begin
                c.cond = COND_ALWAYS; c.target = STEP_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/text_console_put_char_top.sv =====
// scrolling text console: screen store, cursor and microcoded control
//
// one input beat per command on s_axis, one result beat per command on m_axis.
// tuser = mode: 0 prints char_code at the cursor, 1 reads cell cell_index.
// newline (char 10) blanks the rest of the bottom row and scrolls.
// scrolling is done by rotating the row base of the screen ram, then
// blanking the new bottom row one cell a cycle.
// a new command can be taken in the cycle after the previous result is loaded;
// the program runs one step a cycle, holding in the idle step until a
// command arrives and in the done step until the output register frees up,
// with at most one screen ram access per step.
// after reset the program sweeps the whole screen ram to load its
// start-up contents; s_axis_tready stays low until that is done.
// a stalled m_axis holds its beat; the next command is still accepted
// and waits in the done step until the output register frees up.
`default_nettype none
module text_console_put_char_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [7:0] char_code, [16:8] cell_index, upper bits zero
    input  wire logic [tcpc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [0] mode
    input  wire logic                               s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [7:0] read_data, [16:8] cursor_index, [17] scrolled, upper bits zero
    output logic      [tcpc_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

    localparam int AW = tcpc_pkg::ADDR_W;
    localparam int CW = tcpc_pkg::COL_W;
    localparam int RW = tcpc_pkg::ROW_W;
    localparam int DW = tcpc_pkg::CHAR_W;

    tcpc_pkg::step_t pc_reg, pc_next;
    tcpc_pkg::ctrl_t ctrl;

    logic [AW-1:0] init_cnt_reg, init_cnt_next;
    logic [RW-1:0] top_reg, top_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          scr_reg, scr_next;
    logic          mode_reg;
    logic [DW-1:0] code_reg;
    logic [AW-1:0] idx_reg;
    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] out_data_reg;
    logic [AW-1:0] out_cur_reg;
    logic          out_scr_reg;

    logic          accept;
    logic          out_free;
    logic          cond_ok;
    logic          out_load;
    logic [RW-1:0] bot_row;
    logic [AW-1:0] ram_addr;
    logic [DW-1:0] ram_wdata;
    logic [DW-1:0] ram_rdata;
    logic [DW-1:0] mapped;
    logic [AW-1:0] cursor_index;

    assign ctrl     = tcpc_pkg::ucode(pc_reg);
    assign accept   = s_axis_tvalid & ctrl.in_ready;
    assign out_free = ~out_valid_reg | m_axis_tready;
    assign out_load = ctrl.out_load & out_free;

    // physical row of the bottom screen row
    assign bot_row      = RW'(tcpc_pkg::ROWS - 1) + top_reg;
    assign cursor_index = {RW'(tcpc_pkg::ROWS - 1), cur_reg};

    always_comb
    begin
        if (code_reg < 8'd32)
        begin
            mapped = tcpc_pkg::CTRL_GLYPH;
        end
        else if (code_reg < 8'd96)
        begin
            mapped = code_reg & 8'd63;
        end
        else if (code_reg < 8'd128)
        begin
            mapped = code_reg - 8'd96;
        end
        else
        begin
            mapped = code_reg;
        end
    end

    always_comb
    begin
        case (ctrl.asel)
            tcpc_pkg::A_CURSOR: ram_addr = {bot_row, cur_reg};
            tcpc_pkg::A_PTR:    ram_addr = {bot_row, ptr_reg};
            tcpc_pkg::A_READ:   ram_addr = {idx_reg[AW-1:CW] + top_reg, idx_reg[CW-1:0]};
            tcpc_pkg::A_INIT:   ram_addr = init_cnt_reg;
            default:            ram_addr = init_cnt_reg;
        endcase
        case (ctrl.dsel)
            tcpc_pkg::D_CHAR:  ram_wdata = mapped;
            tcpc_pkg::D_BLANK: ram_wdata = tcpc_pkg::BLANK;
            tcpc_pkg::D_MARK:  ram_wdata = tcpc_pkg::CURSOR_MARK;
            tcpc_pkg::D_INIT:  ram_wdata = (init_cnt_reg == AW'(tcpc_pkg::BOTTOM_ROW))
                                         ? tcpc_pkg::CURSOR_MARK : tcpc_pkg::FILL;
            default:           ram_wdata = tcpc_pkg::FILL;
        endcase
    end

    tcpc_ram #(
        .WIDTH (DW),
        .DEPTH (tcpc_pkg::SCREEN_CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ctrl.we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ctrl.re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        case (ctrl.cond)
            tcpc_pkg::COND_ALWAYS:    cond_ok = 1'b1;
            tcpc_pkg::COND_IN_ACCEPT: cond_ok = accept;
            tcpc_pkg::COND_MODE_READ: cond_ok = mode_reg;
            tcpc_pkg::COND_NEWLINE:   cond_ok = (code_reg == tcpc_pkg::NEWLINE);
            tcpc_pkg::COND_COL_LAST:  cond_ok = (cur_reg == CW'(tcpc_pkg::COLUMNS - 1));
            tcpc_pkg::COND_PTR_MORE:  cond_ok = (ptr_reg != CW'(tcpc_pkg::COLUMNS - 1));
            tcpc_pkg::COND_INIT_MORE: cond_ok = (init_cnt_reg != AW'(tcpc_pkg::SCREEN_CELLS - 1));
            tcpc_pkg::COND_OUT_FREE:  cond_ok = out_free;
            default:                  cond_ok = 1'b0;
        endcase
        if (cond_ok)
        begin
            pc_next = ctrl.target;
        end
        else if (ctrl.stay)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + 4'd1;
        end
    end

    // datapath register updates
    always_comb
    begin
        init_cnt_next = ctrl.init_inc ? init_cnt_reg + AW'(1) : init_cnt_reg;
        top_next      = ctrl.top_inc ? top_reg + RW'(1) : top_reg;
        case (ctrl.cur_op)
            tcpc_pkg::C_INC:  cur_next = cur_reg + CW'(1);
            tcpc_pkg::C_ZERO: cur_next = '0;
            default:          cur_next = cur_reg;
        endcase
        case (ctrl.ptr_op)
            tcpc_pkg::P_LOAD:  ptr_next = cur_reg;
            tcpc_pkg::P_INC:   ptr_next = ptr_reg + CW'(1);
            tcpc_pkg::P_CLEAR: ptr_next = '0;
            default:           ptr_next = ptr_reg;
        endcase
        if (ctrl.scr_set)
        begin
            scr_next = 1'b1;
        end
        else if (ctrl.scr_clr)
        begin
            scr_next = 1'b0;
        end
        else
        begin
            scr_next = scr_reg;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= tcpc_pkg::STEP_INIT;
            init_cnt_reg  <= '0;
            top_reg       <= '0;
            cur_reg       <= '0;
            ptr_reg       <= '0;
            scr_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            init_cnt_reg  <= init_cnt_next;
            top_reg       <= top_next;
            cur_reg       <= cur_next;
            ptr_reg       <= ptr_next;
            scr_reg       <= scr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= s_axis_tuser;
            code_reg <= s_axis_tdata[DW-1:0];
            idx_reg  <= s_axis_tdata[DW+AW-1:DW];
        end
        if (out_load)
        begin
            out_data_reg <= mode_reg ? ram_rdata : '0;
            out_cur_reg  <= cursor_index;
            out_scr_reg  <= scr_reg;
        end
    end

    assign s_axis_tready = ctrl.in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(tcpc_pkg::M_TDATA_W - DW - AW - 1){1'b0}},
                            out_scr_reg, out_cur_reg, out_data_reg};

endmodule
`default_nettype wire

// ===== hdl/tcpc_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module tcpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/tcpc_checker.sv =====
// port-level checks for the text console, bound to the top level
`default_nettype none
module tcpc_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [tcpc_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW = tcpc_pkg::ADDR_W;
    localparam int DW = tcpc_pkg::CHAR_W;

    // the cursor never leaves the bottom row
    a_cursor_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[DW+AW-1:DW] >= AW'(tcpc_pkg::BOTTOM_ROW))
        else $error("cursor outside bottom row");

    // a scroll always leaves the cursor at the start of the bottom row
    a_scroll_home: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[DW+AW] |->
            m_axis_tdata[DW+AW-1:DW] == AW'(tcpc_pkg::BOTTOM_ROW))
        else $error("scroll without cursor at row start");

    // one command in flight: no beat accepted right after another
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("back to back accept");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

endmodule

bind text_console_put_char_top tcpc_checker u_tcpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
